// ===== design/dcmr_pkg.sv =====
// dcmr_pkg: shared types, constants and fixed-point helpers for dcm_renormalize
// depends on nothing
`timescale 1ns / 1ps
package dcmr_pkg;
  localparam int QFRAC = 29;
  // cycles from an input transfer to its result strobe
  localparam int LATENCY = 10;
  localparam logic signed [35:0] Q_THREE = 36'sd3 <<< QFRAC;

  typedef logic signed [31:0] q_t;
  typedef logic signed [35:0] wq_t;
  typedef struct packed {
    q_t x;
    q_t y;
    q_t z;
  } vec_t;

  // clamp a wide signed value to q format
  function automatic q_t sat_q(input wq_t v);
    if (v > 36'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // truncated q product, widened to 36 bits (|product>>29| <= 2^33, sums of three fit)
  function automatic wq_t qmul(input q_t a, input q_t b);
    logic signed [63:0] p;
    p = a * b;
    return {p[63], p[63:29]};
  endfunction

  // half-error product: shift by 30
  function automatic wq_t qmul_h(input q_t a, input q_t b);
    logic signed [63:0] p;
    p = a * b;
    return {{2{p[63]}}, p[63:30]};
  endfunction
endpackage

// ===== design/dcmr_dot.sv =====
// dcmr_dot: registered saturated q dot product, two stages (multiply, sum)
// depends on dcmr_pkg
`timescale 1ns / 1ps
module dcmr_dot (
  input  logic            clk,
  input  dcmr_pkg::vec_t  a,
  input  dcmr_pkg::vec_t  b,
  output dcmr_pkg::q_t    dot
);
  dcmr_pkg::wq_t px, py, pz;
  always_ff @(posedge clk) begin
    px  <= dcmr_pkg::qmul(a.x, b.x);
    py  <= dcmr_pkg::qmul(a.y, b.y);
    pz  <= dcmr_pkg::qmul(a.z, b.z);
    dot <= dcmr_pkg::sat_q(px + py + pz);
  end
endmodule

// ===== design/dcmr_scale.sv =====
// dcmr_scale: taylor length correction of one row, four stages
// depends on dcmr_pkg, dcmr_dot
`timescale 1ns / 1ps
module dcmr_scale (
  input  logic            clk,
  input  dcmr_pkg::vec_t  v,
  output dcmr_pkg::vec_t  r
);
  dcmr_pkg::q_t   n, f;
  dcmr_pkg::vec_t v1, v2, v3;
  dcmr_pkg::wq_t  d;

  dcmr_dot u_norm (.clk(clk), .a(v), .b(v), .dot(n));

  always_comb begin
    d = dcmr_pkg::Q_THREE - 36'(n);
  end

  always_ff @(posedge clk) begin
    v1  <= v;
    v2  <= v1;
    v3  <= v2;
    f   <= dcmr_pkg::sat_q(d >>> 1);
    r.x <= dcmr_pkg::sat_q(dcmr_pkg::qmul(v3.x, f));
    r.y <= dcmr_pkg::sat_q(dcmr_pkg::qmul(v3.y, f));
    r.z <= dcmr_pkg::sat_q(dcmr_pkg::qmul(v3.z, f));
  end
endmodule

// ===== design/dcm_renormalize.sv =====
// dcm_renormalize: top level, renormalizes a direction cosine matrix
// depends on dcmr_pkg, dcmr_dot, dcmr_scale
`timescale 1ns / 1ps
// one matrix (two rows, q2.29) is taken per cycle whenever start is high;
// busy is always low since the pipeline never stalls. results come out
// in order, each with done high for one cycle; the receiver cannot hold
// them off and needs none. stages: error dot product (2), half-error
// products (1), row correction (1), cross products (1), cross difference
// (1), then length scaling of all three rows (4).
module dcm_renormalize (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  row0_x, row0_y, row0_z,
  input  logic signed [31:0]  row1_x, row1_y, row1_z,
  output logic                done,
  output logic signed [31:0]  out0_x, out0_y, out0_z,
  output logic signed [31:0]  out1_x, out1_y, out1_z,
  output logic signed [31:0]  out2_x, out2_y, out2_z
);
  dcmr_pkg::vec_t a0, b0, a1, b1, a2, b2, ca, cb, cc;
  dcmr_pkg::vec_t ca5, cb5, ca6, cb6, ra, rb, rc;
  dcmr_pkg::q_t   e;
  dcmr_pkg::wq_t  ha_x, ha_y, ha_z, hb_x, hb_y, hb_z;
  dcmr_pkg::wq_t  p0, p1, p2, p3, p4, p5;
  logic [dcmr_pkg::LATENCY-1:0] vld;

  assign busy = 1'b0;
  assign a0 = '{x: row0_x, y: row0_y, z: row0_z};
  assign b0 = '{x: row1_x, y: row1_y, z: row1_z};

  // orthogonality error of the two rows, from the registered dot product
  dcmr_dot u_err (.clk(clk), .a(a0), .b(b0), .dot(e));

  always_ff @(posedge clk) begin
    a1 <= a0;
    b1 <= b0;
    a2 <= a1;
    b2 <= b1;
    // half error times the other row
    ha_x <= dcmr_pkg::qmul_h(b2.x, e);
    ha_y <= dcmr_pkg::qmul_h(b2.y, e);
    ha_z <= dcmr_pkg::qmul_h(b2.z, e);
    hb_x <= dcmr_pkg::qmul_h(a2.x, e);
    hb_y <= dcmr_pkg::qmul_h(a2.y, e);
    hb_z <= dcmr_pkg::qmul_h(a2.z, e);
    ca5  <= a2;
    cb5  <= b2;
    // corrected rows
    ca.x <= dcmr_pkg::sat_q(36'(ca5.x) - ha_x);
    ca.y <= dcmr_pkg::sat_q(36'(ca5.y) - ha_y);
    ca.z <= dcmr_pkg::sat_q(36'(ca5.z) - ha_z);
    cb.x <= dcmr_pkg::sat_q(36'(cb5.x) - hb_x);
    cb.y <= dcmr_pkg::sat_q(36'(cb5.y) - hb_y);
    cb.z <= dcmr_pkg::sat_q(36'(cb5.z) - hb_z);
    // cross product terms
    p0 <= dcmr_pkg::qmul(ca.y, cb.z);
    p1 <= dcmr_pkg::qmul(ca.z, cb.y);
    p2 <= dcmr_pkg::qmul(ca.z, cb.x);
    p3 <= dcmr_pkg::qmul(ca.x, cb.z);
    p4 <= dcmr_pkg::qmul(ca.x, cb.y);
    p5 <= dcmr_pkg::qmul(ca.y, cb.x);
    ca6 <= ca;
    cb6 <= cb;
    cc.x <= dcmr_pkg::sat_q(p0 - p1);
    cc.y <= dcmr_pkg::sat_q(p2 - p3);
    cc.z <= dcmr_pkg::sat_q(p4 - p5);
  end

  // rows are registered again (ca7, cb7) so all three enter scaling together
  dcmr_pkg::vec_t ca7, cb7;
  always_ff @(posedge clk) begin
    ca7 <= ca6;
    cb7 <= cb6;
  end

  dcmr_scale u_sa (.clk(clk), .v(ca7), .r(ra));
  dcmr_scale u_sb (.clk(clk), .v(cb7), .r(rb));
  dcmr_scale u_sc (.clk(clk), .v(cc),  .r(rc));

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[dcmr_pkg::LATENCY-2:0], start};
    end
  end

  assign done   = vld[dcmr_pkg::LATENCY-1];
  assign out0_x = ra.x;
  assign out0_y = ra.y;
  assign out0_z = ra.z;
  assign out1_x = rb.x;
  assign out1_y = rb.y;
  assign out1_z = rb.z;
  assign out2_x = rc.x;
  assign out2_y = rc.y;
  assign out2_z = rc.z;
endmodule

// ===== design/dcmr_checker.sv =====
// dcmr_checker: port-level assertions for dcm_renormalize, bound to the top level
// depends on dcm_renormalize (bind target only)
`timescale 1ns / 1ps
module dcmr_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  a_never_busy: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_done_after: assert property (@(posedge clk) disable iff (rst)
    (start && !$past(rst, 10) && !$past(rst, 9) && !$past(rst, 1) && !rst) |-> ##10 done)
    else $error("transfer without result");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(rst, 10)) |-> $past(start, 10))
    else $error("result without transfer");
endmodule

bind dcm_renormalize dcmr_checker u_dcmr_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);

// ===== dv/tb.sv =====
// tb: self-checking bench for dcm_renormalize, predicts each renormalized matrix
// depends on dcmr_pkg (q_t, LATENCY) and the dcm_renormalize rtl
`timescale 1ns / 1ps
module tb;
  typedef dcmr_pkg::q_t q_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM = 600;
  localparam logic signed [63:0] QMAX = 64'sd2147483647;
  localparam logic signed [63:0] QMIN = -64'sd2147483648;
  localparam logic signed [63:0] THREE = 64'sd3 <<< 29;
  localparam logic signed [31:0] ONE = 32'sd1 <<< 29;

  typedef struct {
    q_t m[9];
  } dcm_t;

  // one directed row: six inputs, optional typed-in expectation
  typedef struct {
    q_t r[6];
    bit has_exp;
    q_t e[9];
  } vec_row_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  q_t row0_x = 0, row0_y = 0, row0_z = 0;
  q_t row1_x = 0, row1_y = 0, row1_z = 0;
  logic done;
  q_t out0_x, out0_y, out0_z, out1_x, out1_y, out1_z, out2_x, out2_y, out2_z;

  dcm_t expected_dcm_q[$];
  int mismatch_count = 0;
  int idle_cycles = 0;

  dcm_renormalize dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  // exact product, arithmetic shift (floor)
  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b, input int sh);
    logic signed [63:0] p;
    p = a * b;
    return p >>> sh;
  endfunction

  function automatic logic signed [63:0] dot3(input logic signed [63:0] a[3],
                                              input logic signed [63:0] b[3]);
    return clamp_q(fx_mul(a[0], b[0], 29) + fx_mul(a[1], b[1], 29) + fx_mul(a[2], b[2], 29));
  endfunction

  // predictor: orthogonalize, cross, then taylor length scaling
  function automatic dcm_t renorm_dcm(input q_t r[6]);
    logic signed [63:0] a[3], b[3], ca[3], cb[3], cc[3], v[3], err, nrm, fac;
    dcm_t res;
    for (int i = 0; i < 3; i++) begin
      a[i] = r[i];
      b[i] = r[3 + i];
    end
    err = dot3(a, b);
    for (int i = 0; i < 3; i++) begin
      ca[i] = clamp_q(a[i] - fx_mul(b[i], err, 30));
      cb[i] = clamp_q(b[i] - fx_mul(a[i], err, 30));
    end
    cc[0] = clamp_q(fx_mul(ca[1], cb[2], 29) - fx_mul(ca[2], cb[1], 29));
    cc[1] = clamp_q(fx_mul(ca[2], cb[0], 29) - fx_mul(ca[0], cb[2], 29));
    cc[2] = clamp_q(fx_mul(ca[0], cb[1], 29) - fx_mul(ca[1], cb[0], 29));
    for (int row = 0; row < 3; row++) begin
      for (int i = 0; i < 3; i++) v[i] = (row == 0) ? ca[i] : (row == 1) ? cb[i] : cc[i];
      nrm = dot3(v, v);
      fac = clamp_q((THREE - nrm) >>> 1);
      for (int i = 0; i < 3; i++) res.m[row * 3 + i] = q_t'(clamp_q(fx_mul(v[i], fac, 29)));
    end
    return res;
  endfunction

  task automatic report_mismatch(input int idx, input q_t got, input q_t exp);
    mismatch_count++;
    $display("mismatch at %0t: element %0d got %0d expected %0d", $time, idx, got, exp);
  endtask

  // drive one matrix and hold start until the transfer is taken
  task automatic send_matrix(input q_t r[6]);
    start <= 1;
    {row0_x, row0_y, row0_z} <= {r[0], r[1], r[2]};
    {row1_x, row1_y, row1_z} <= {r[3], r[4], r[5]};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic q_t rand_q(input int mode);
    case (mode)
      0: return q_t'($urandom);
      1: return q_t'($urandom_range(0, 2 * ONE)) - ONE;  // near-unit range
      default: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  // result side: compare every done cycle with the oldest prediction
  always @(posedge clk) begin
    q_t got[9];
    dcm_t exp_dcm;
    if (!rst && done) begin
      got = '{out0_x, out0_y, out0_z, out1_x, out1_y, out1_z, out2_x, out2_y, out2_z};
      if (expected_dcm_q.size() == 0) begin
        mismatch_count++;
        $display("unexpected result at %0t", $time);
      end else begin
        exp_dcm = expected_dcm_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== exp_dcm.m[i]) report_mismatch(i, got[i], exp_dcm.m[i]);
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    vec_row_t dir_tbl[$];
    vec_row_t row;
    q_t r[6];
    dcm_t pred;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // zero matrix: everything stays zero
    row.r = '{0, 0, 0, 0, 0, 0};
    row.has_exp = 1;
    row.e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    dir_tbl.push_back(row);
    // identity rows: already orthonormal, comes back unchanged
    row.r = '{ONE, 0, 0, 0, ONE, 0};
    row.e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
    dir_tbl.push_back(row);
    row.r = '{-ONE, 0, 0, 0, 0, ONE};
    row.e = '{-ONE, 0, 0, 0, 0, ONE, 0, ONE, 0};
    dir_tbl.push_back(row);
    row.has_exp = 0;
    // extremes, saturation, unequal lengths, near-parallel rows
    row.r = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    dir_tbl.push_back(row);
    row.r = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh80000000, 32'sh80000000, 32'sh80000000};
    dir_tbl.push_back(row);
    row.r = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000,
              32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    dir_tbl.push_back(row);
    row.r = '{-1, -1, -1, -1, -1, -1};
    dir_tbl.push_back(row);
    row.r = '{1, 1, 1, 1, 1, 1};
    dir_tbl.push_back(row);
    row.r = '{ONE / 2, ONE / 2, 0, ONE / 2, -ONE / 2, ONE / 8};
    dir_tbl.push_back(row);
    row.r = '{ONE, ONE / 64, 0, ONE / 64, ONE, 0};
    dir_tbl.push_back(row);
    row.r = '{ONE, 0, 0, ONE, 0, 0};
    dir_tbl.push_back(row);
    row.r = '{2 * ONE, 0, 0, 0, ONE / 4, 0};
    dir_tbl.push_back(row);

    foreach (dir_tbl[k]) begin
      pred = renorm_dcm(dir_tbl[k].r);
      if (dir_tbl[k].has_exp)
        for (int i = 0; i < 9; i++)
          if (pred.m[i] !== dir_tbl[k].e[i]) report_mismatch(i, pred.m[i], dir_tbl[k].e[i]);
      expected_dcm_q.push_back(pred);
      send_matrix(dir_tbl[k].r);
    end
    start <= 0;

    // drain fully before the random part
    while (expected_dcm_q.size() != 0) @(posedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      // idle cycles in about 14 of 100, none in the middle stretch
      while ((n < 200 || n > 400) && $urandom_range(0, 99) < 14) begin
        start <= 0;
        @(posedge clk);
      end
      // hold off until every pending transfer has come back
      if (n == 300) begin
        start <= 0;
        while (expected_dcm_q.size() != 0) @(posedge clk);
      end
      begin
        int mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 6; i++)
          r[i] = rand_q(mode < 3 ? 0 : (mode < 9 ? 1 : ($urandom_range(0, 3) == 0 ? 2 : 1)));
      end
      expected_dcm_q.push_back(renorm_dcm(r));
      send_matrix(r);
    end
    start <= 0;

    while (expected_dcm_q.size() != 0) @(posedge clk);
    repeat (dcmr_pkg::LATENCY + 5) @(posedge clk);
    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
